// ===== design/tlv_element_header_parser_defines.svh =====
// assertion macros used by the checker module
`ifndef TLV_ELEMENT_HEADER_PARSER_DEFINES_SVH
`define TLV_ELEMENT_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TLVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define TLVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define TLVP_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tlvp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlvp_pkg;

  localparam int TLVP_POSITION_BITS_DEF = 32;

  localparam int TLVP_BYTE_W  = 8;
  localparam int TLVP_TOTAL_W = 32;
  localparam int TLVP_CODE_W  = 4;
  localparam int TLVP_KIND_W  = 2;
  localparam int TLVP_TAG_W   = 11;
  localparam int TLVP_RAW_W   = 15;
  localparam int TLVP_LEN_W   = 64;
  localparam int TLVP_ADDR_W  = 2;

  // result kinds
  localparam logic [TLVP_KIND_W-1:0] TLVP_KIND_HDR = 2'd0;
  localparam logic [TLVP_KIND_W-1:0] TLVP_KIND_VAL = 2'd1;
  localparam logic [TLVP_KIND_W-1:0] TLVP_KIND_OVR = 2'd2;
  localparam logic [TLVP_KIND_W-1:0] TLVP_KIND_END = 2'd3;

  // config register indexes
  localparam logic [TLVP_ADDR_W-1:0] TLVP_REG_TOTAL_SIZE   = 2'd0;
  localparam logic [TLVP_ADDR_W-1:0] TLVP_REG_INTEGER_CODE = 2'd1;
  localparam logic [TLVP_ADDR_W-1:0] TLVP_REG_STRING_CODE  = 2'd2;
  localparam logic [TLVP_ADDR_W-1:0] TLVP_REG_SET_CODE     = 2'd3;

  localparam logic [TLVP_TOTAL_W-1:0] TLVP_TOTAL_SIZE_RST   = '0;
  localparam logic [TLVP_CODE_W-1:0]  TLVP_INTEGER_CODE_RST = 4'd3;
  localparam logic [TLVP_CODE_W-1:0]  TLVP_STRING_CODE_RST  = 4'd5;
  localparam logic [TLVP_CODE_W-1:0]  TLVP_SET_CODE_RST     = 4'd0;

  typedef struct packed {
    logic [TLVP_TOTAL_W-1:0] total_size;
    logic [TLVP_CODE_W-1:0]  integer_code;
    logic [TLVP_CODE_W-1:0]  string_code;
    logic [TLVP_CODE_W-1:0]  set_code;
  } tlvp_cfg_t;

  typedef struct packed {
    logic [TLVP_KIND_W-1:0] kind;
    logic [TLVP_TAG_W-1:0]  tag;
    logic [TLVP_CODE_W-1:0] data_type;
    logic                   type_known;
    logic [TLVP_LEN_W-1:0]  length;
    logic [TLVP_BYTE_W-1:0] value_byte;
    logic                   last;
  } tlvp_res_t;

endpackage

`default_nettype wire

// ===== design/tlvp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlvp_in_if import tlvp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TLVP_BYTE_W-1:0] in_byte;
  logic                   first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink (input valid, input in_byte, input first, output ready);
endinterface

interface tlvp_out_if import tlvp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [TLVP_KIND_W-1:0] kind;
  logic [TLVP_TAG_W-1:0]  tag;
  logic [TLVP_CODE_W-1:0] data_type;
  logic                   type_known;
  logic [TLVP_LEN_W-1:0]  length;
  logic [TLVP_BYTE_W-1:0] value_byte;
  logic                   last;

  modport source (output valid, output kind, output tag, output data_type,
                  output type_known, output length, output value_byte,
                  output last, input ready);
  modport sink (input valid, input kind, input tag, input data_type,
                input type_known, input length, input value_byte,
                input last, output ready);
endinterface

interface tlvp_cfg_if import tlvp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [TLVP_ADDR_W-1:0]  addr;
  logic [TLVP_TOTAL_W-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tlvp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlvp_parse import tlvp_pkg::*; #(
  parameter int POSITION_BITS = TLVP_POSITION_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   fire,
  input  wire logic [TLVP_BYTE_W-1:0] in_byte,
  input  wire logic                   in_first,
  input  wire tlvp_cfg_t              cfg,
  output logic                        res_valid,
  output tlvp_res_t                   res
);

  localparam int CMP_W = (POSITION_BITS > TLVP_TOTAL_W) ? POSITION_BITS : TLVP_TOTAL_W;

  localparam logic [2:0] PH_TAG1  = 3'd0;
  localparam logic [2:0] PH_TAG2  = 3'd1;
  localparam logic [2:0] PH_LEN1  = 3'd2;
  localparam logic [2:0] PH_LENN = 3'd3;
  localparam logic [2:0] PH_VALUE = 3'd4;

  logic [2:0]               phase_r, phase_nxt, phase_cur;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_cur, pos_inc;
  logic [6:0]               tlow_r, tlow_nxt, tlow_cur;
  logic [TLVP_LEN_W-1:0]    len_r, len_nxt, len_cur;
  logic [6:0]               lleft_r, lleft_nxt, lleft_cur;
  logic [TLVP_LEN_W-1:0]    vleft_r, vleft_nxt, vleft_cur;
  logic [TLVP_RAW_W-1:0]    raw_r, raw_nxt, raw_cur;
  logic                     ended_r, ended_nxt, ended_cur;

  logic                     active, at_end;
  logic [TLVP_TOTAL_W-1:0]  room;
  logic                     fin, end_s, emit, last_w, known_en, type_hit;
  logic [TLVP_KIND_W-1:0]   kind_w;
  logic [TLVP_BYTE_W-1:0]   vbyte_w;

  // a first byte restarts from the cleared state
  assign phase_cur = in_first ? PH_TAG1 : phase_r;
  assign pos_cur   = in_first ? '0 : pos_r;
  assign tlow_cur  = in_first ? '0 : tlow_r;
  assign len_cur   = in_first ? '0 : len_r;
  assign lleft_cur = in_first ? '0 : lleft_r;
  assign vleft_cur = in_first ? '0 : vleft_r;
  assign raw_cur   = in_first ? '0 : raw_r;
  assign ended_cur = in_first ? 1'b0 : ended_r;

  assign pos_inc = pos_cur + POSITION_BITS'(1);
  assign active  = !ended_cur && (CMP_W'(pos_cur) < CMP_W'(cfg.total_size));
  assign at_end  = CMP_W'(pos_inc) >= CMP_W'(cfg.total_size);
  assign room    = TLVP_TOTAL_W'(CMP_W'(cfg.total_size) - CMP_W'(pos_inc));

  always_comb begin
    phase_nxt = phase_cur;
    pos_nxt   = pos_cur;
    tlow_nxt  = tlow_cur;
    len_nxt   = len_cur;
    lleft_nxt = lleft_cur;
    vleft_nxt = vleft_cur;
    raw_nxt   = raw_cur;
    ended_nxt = ended_cur;
    fin       = 1'b0;
    end_s     = 1'b0;
    emit      = 1'b0;
    kind_w    = TLVP_KIND_HDR;
    vbyte_w   = '0;
    last_w    = 1'b0;
    known_en  = 1'b0;

    if (active) begin
      pos_nxt = pos_inc;
      unique case (phase_cur)
        PH_TAG1: begin
          if (in_byte[7]) begin
            tlow_nxt = in_byte[6:0];
            if (at_end) begin
              end_s = 1'b1;
            end else begin
              phase_nxt = PH_TAG2;
            end
          end else begin
            raw_nxt = TLVP_RAW_W'(in_byte);
            if (in_byte == '0 || at_end) begin
              end_s = 1'b1;
            end else begin
              phase_nxt = PH_LEN1;
            end
          end
        end
        PH_TAG2: begin
          raw_nxt = {in_byte, tlow_cur};
          if (raw_nxt == '0 || at_end) begin
            end_s = 1'b1;
          end else begin
            phase_nxt = PH_LEN1;
          end
        end
        PH_LEN1: begin
          if (in_byte[7]) begin
            len_nxt = '0;
            if (TLVP_TOTAL_W'(in_byte[6:0]) > room || in_byte[6:0] == '0) begin
              fin = 1'b1;
            end else begin
              lleft_nxt = in_byte[6:0];
              phase_nxt = PH_LENN;
            end
          end else begin
            len_nxt = TLVP_LEN_W'(in_byte);
            fin     = 1'b1;
          end
        end
        PH_LENN: begin
          len_nxt   = {len_cur[TLVP_LEN_W-TLVP_BYTE_W-1:0], in_byte};
          lleft_nxt = lleft_cur - 7'd1;
          if (lleft_nxt == '0) begin
            fin = 1'b1;
          end
        end
        PH_VALUE: begin
          vleft_nxt = vleft_cur - TLVP_LEN_W'(1);
          emit      = 1'b1;
          kind_w    = TLVP_KIND_VAL;
          vbyte_w   = in_byte;
          known_en  = 1'b1;
          if (vleft_nxt == '0) begin
            phase_nxt = PH_TAG1;
            last_w    = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_TAG1;
        end
      endcase

      // header complete: check the length against what is left of the buffer
      if (fin) begin
        if (len_nxt > TLVP_LEN_W'(room)) begin
          len_nxt   = '0;
          phase_nxt = PH_TAG1;
          if (raw_nxt[TLVP_RAW_W-1:4] == '0) begin
            end_s = 1'b1;
          end else begin
            emit   = 1'b1;
            kind_w = TLVP_KIND_OVR;
            last_w = 1'b1;
          end
        end else if (raw_nxt[TLVP_RAW_W-1:4] == '0 && len_nxt == '0) begin
          end_s = 1'b1;
        end else if (len_nxt == '0) begin
          phase_nxt = PH_TAG1;
          emit      = 1'b1;
          last_w    = 1'b1;
          known_en  = 1'b1;
        end else begin
          vleft_nxt = len_nxt;
          phase_nxt = PH_VALUE;
          emit      = 1'b1;
          known_en  = 1'b1;
        end
      end

      if (end_s) begin
        ended_nxt = 1'b1;
        phase_nxt = PH_TAG1;
      end
    end
  end

  assign type_hit = (raw_nxt[3:0] == cfg.integer_code) ||
                    (raw_nxt[3:0] == cfg.string_code) ||
                    (raw_nxt[3:0] == cfg.set_code);

  always_comb begin
    res = '0;
    if (end_s) begin
      res.kind = TLVP_KIND_END;
    end else if (emit) begin
      res.kind       = kind_w;
      res.tag        = raw_nxt[TLVP_RAW_W-1:4];
      res.data_type  = raw_nxt[3:0];
      res.type_known = known_en && type_hit;
      res.length     = len_nxt;
      res.value_byte = vbyte_w;
      res.last       = last_w;
    end
  end

  assign res_valid = end_s || emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG1;
      pos_r   <= '0;
      tlow_r  <= '0;
      len_r   <= '0;
      lleft_r <= '0;
      vleft_r <= '0;
      raw_r   <= '0;
      ended_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tlow_r  <= tlow_nxt;
      len_r   <= len_nxt;
      lleft_r <= lleft_nxt;
      vleft_r <= vleft_nxt;
      raw_r   <= raw_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tlv_element_header_parser.sv =====
// a word accepted into the input register reaches the output register through the parser
// throughput: one input word per cycle while the output is not stalled; the phase machine
//   and its counters update once per byte, between the input register and the output register
// a stalled output holds its word; input keeps flowing while the output register drains
// reset (rst_n low, synchronous): parser back at the tag phase, both stages empty,
//   config registers at total_size 0, integer 3, string 5, set 0
`timescale 1ns / 1ps
`default_nettype none

module tlv_element_header_parser import tlvp_pkg::*; #(
  parameter int POSITION_BITS = TLVP_POSITION_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tlvp_in_if.sink    in_ch,
  tlvp_out_if.source out_ch,
  tlvp_cfg_if.sink   cfg_ch
);

  // configuration registers, always ready
  tlvp_cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_size   <= TLVP_TOTAL_SIZE_RST;
      cfg_r.integer_code <= TLVP_INTEGER_CODE_RST;
      cfg_r.string_code  <= TLVP_STRING_CODE_RST;
      cfg_r.set_code     <= TLVP_SET_CODE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        TLVP_REG_TOTAL_SIZE:   cfg_r.total_size   <= cfg_ch.data;
        TLVP_REG_INTEGER_CODE: cfg_r.integer_code <= cfg_ch.data[TLVP_CODE_W-1:0];
        TLVP_REG_STRING_CODE:  cfg_r.string_code  <= cfg_ch.data[TLVP_CODE_W-1:0];
        TLVP_REG_SET_CODE:     cfg_r.set_code     <= cfg_ch.data[TLVP_CODE_W-1:0];
      endcase
    end
  end

  // input register: one buffered word
  logic                   stg_valid_r;
  logic [TLVP_BYTE_W-1:0] stg_byte_r;
  logic                   stg_first_r;
  logic                   stg_fire;

  // output register
  logic      out_valid_r;
  tlvp_res_t out_r;

  // parser result for the buffered word
  logic      res_valid;
  tlvp_res_t res;

  // the buffered word moves on once the output slot is free or being emptied
  assign stg_fire    = stg_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || stg_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stg_valid_r <= 1'b1;
    end else if (stg_fire) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_byte_r  <= in_ch.in_byte;
      stg_first_r <= in_ch.first;
    end
  end

  // phase machine, counters and length decode
  tlvp_parse #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (stg_fire),
    .in_byte  (stg_byte_r),
    .in_first (stg_first_r),
    .cfg      (cfg_r),
    .res_valid(res_valid),
    .res      (res)
  );

  // a byte that yields no result leaves the output slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.tag        = out_r.tag;
  assign out_ch.data_type  = out_r.data_type;
  assign out_ch.type_known = out_r.type_known;
  assign out_ch.length     = out_r.length;
  assign out_ch.value_byte = out_r.value_byte;
  assign out_ch.last       = out_r.last;

endmodule

`default_nettype wire

// ===== design/tlvp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "tlv_element_header_parser_defines.svh"

module tlvp_checker import tlvp_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [TLVP_KIND_W-1:0] kind,
  input wire logic [TLVP_TAG_W-1:0]  tag,
  input wire logic [TLVP_CODE_W-1:0] data_type,
  input wire logic                   type_known,
  input wire logic [TLVP_LEN_W-1:0]  length,
  input wire logic [TLVP_BYTE_W-1:0] value_byte,
  input wire logic                   last
);

  logic is_end, is_ovr, is_hdr;

  assign is_end = out_valid && (kind == TLVP_KIND_END);
  assign is_ovr = out_valid && (kind == TLVP_KIND_OVR);
  assign is_hdr = out_valid && (kind == TLVP_KIND_HDR);

  `TLVP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(tag) && $stable(length) && $stable(value_byte) && $stable(last), "stalled result word changed")
  `TLVP_ASSERT_IMP(a_end_zero, is_end, tag == '0 && data_type == '0 && !type_known && length == '0 && value_byte == '0 && !last, "end of stream word carries data")
  `TLVP_ASSERT_IMP(a_ovr_hdr, is_ovr, length == '0 && last && !type_known && value_byte == '0, "overrun header malformed")
  `TLVP_ASSERT_IMP(a_hdr_last, is_hdr, (last == (length == '0)) && value_byte == '0, "header last mark does not match length")
  `TLVP_ASSERT_NXT_ALL(a_rst_empty, !rst_n, !out_valid, "output valid right after reset")

endmodule

bind tlv_element_header_parser tlvp_checker u_tlvp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .tag       (out_ch.tag),
  .data_type (out_ch.data_type),
  .type_known(out_ch.type_known),
  .length    (out_ch.length),
  .value_byte(out_ch.value_byte),
  .last      (out_ch.last)
);

`default_nettype wire

// ===== tb/tlv_element_header_parser_tb.sv =====
`timescale 1ns / 1ps

module tlv_element_header_parser_tb;
  import tlvp_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // stimulus size for the random part
  localparam int unsigned TARGET_BYTES = 1900;
  // a word passes the input register and the output register before it shows; margin on top
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    P_TAG1,
    P_TAG2,
    P_LEN1,
    P_LENN,
    P_VALUE
  } parse_phase_e;

  // one word on the input channel
  typedef struct packed {
    logic [TLVP_BYTE_W-1:0] b;
    logic                   first;
  } in_word_t;

  logic clk;
  logic rst_n;

  tlvp_in_if  in_if ();
  tlvp_out_if out_if ();
  tlvp_cfg_if cfg_if ();

  tlv_element_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // words waiting for the driver, results waiting for the monitor
  in_word_t  tx_words[$];
  tlvp_res_t expected_words[$];
  // buffer under construction
  logic [TLVP_BYTE_W-1:0] frame[$];

  int unsigned cfg_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_queued = 0;
  logic        in_taken = 1'b0;
  // no idling on either side while set
  logic        calm = 1'b0;

  // predictor copy of the config registers
  logic [TLVP_TOTAL_W-1:0] m_total = TLVP_TOTAL_SIZE_RST;
  logic [TLVP_CODE_W-1:0]  m_int   = TLVP_INTEGER_CODE_RST;
  logic [TLVP_CODE_W-1:0]  m_str   = TLVP_STRING_CODE_RST;
  logic [TLVP_CODE_W-1:0]  m_set   = TLVP_SET_CODE_RST;

  // predictor copy of the parser state
  parse_phase_e            ph       = P_TAG1;
  logic [TLVP_TOTAL_W-1:0] pos      = '0;
  logic [6:0]              tag_lo   = '0;
  logic [TLVP_LEN_W-1:0]   len_acc  = '0;
  logic [6:0]              len_left = '0;
  logic [TLVP_LEN_W-1:0]   val_left = '0;
  logic [TLVP_RAW_W-1:0]   raw_tag  = '0;
  logic                    ended    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // type nibble matches one of the three configured codes
  function automatic logic code_hit();
    return (raw_tag[3:0] == m_int) || (raw_tag[3:0] == m_str) || (raw_tag[3:0] == m_set);
  endfunction

  task automatic push_word(input logic [TLVP_KIND_W-1:0] kind,
                           input logic [TLVP_BYTE_W-1:0] vb,
                           input logic last, input logic known);
    tlvp_res_t w;
    w.kind       = kind;
    w.tag        = raw_tag[14:4];
    w.data_type  = raw_tag[3:0];
    w.type_known = known;
    w.length     = len_acc;
    w.value_byte = vb;
    w.last       = last;
    expected_words.push_back(w);
  endtask

  // end marker carries nothing but its kind; parser then sleeps until first
  task automatic end_of_stream();
    tlvp_res_t w;
    w      = '0;
    w.kind = TLVP_KIND_END;
    expected_words.push_back(w);
    ended = 1'b1;
    ph    = P_TAG1;
  endtask

  // length is complete and pos points past the header
  task automatic close_header();
    logic [TLVP_LEN_W-1:0] room;
    room = {32'd0, m_total - pos};
    if (len_acc > room) begin
      // value would run past the buffer end
      len_acc = '0;
      ph      = P_TAG1;
      if (raw_tag[14:4] == '0) end_of_stream();
      else push_word(TLVP_KIND_OVR, '0, 1'b1, 1'b0);
    end else if (raw_tag[14:4] == '0 && len_acc == '0) begin
      end_of_stream();
    end else if (len_acc == '0) begin
      ph = P_TAG1;
      push_word(TLVP_KIND_HDR, '0, 1'b1, code_hit());
    end else begin
      val_left = len_acc;
      ph       = P_VALUE;
      push_word(TLVP_KIND_HDR, '0, 1'b0, code_hit());
    end
  endtask

  task automatic parse_byte(input logic [TLVP_BYTE_W-1:0] b, input logic first);
    logic [6:0] cnt;
    if (first) begin
      ph       = P_TAG1;
      pos      = '0;
      tag_lo   = '0;
      len_acc  = '0;
      len_left = '0;
      val_left = '0;
      raw_tag  = '0;
      ended    = 1'b0;
    end
    // ended stream or buffer used up: byte dropped silently
    if (ended || pos >= m_total) return;
    pos = pos + 1'b1;
    case (ph)
      P_TAG1: begin
        if (b[7]) begin
          // two-byte tag, low seven bits first
          tag_lo = b[6:0];
          if (pos >= m_total) end_of_stream();
          else ph = P_TAG2;
        end else begin
          raw_tag = {7'd0, b};
          if (b == '0 || pos >= m_total) end_of_stream();
          else ph = P_LEN1;
        end
      end
      P_TAG2: begin
        raw_tag = {b, tag_lo};
        if (raw_tag == '0 || pos >= m_total) end_of_stream();
        else ph = P_LEN1;
      end
      P_LEN1: begin
        if (b[7]) begin
          // long form: count of big-endian length bytes follows
          cnt     = b[6:0];
          len_acc = '0;
          if ({25'd0, cnt} > m_total - pos || cnt == '0) begin
            close_header();
          end else begin
            len_left = cnt;
            ph       = P_LENN;
          end
        end else begin
          len_acc = {56'd0, b};
          close_header();
        end
      end
      P_LENN: begin
        // only the low 64 bits survive
        len_acc  = {len_acc[55:0], b};
        len_left = len_left - 1'b1;
        if (len_left == '0) close_header();
      end
      default: begin
        val_left = val_left - 1'b1;
        push_word(TLVP_KIND_VAL, b, val_left == '0, code_hit());
        if (val_left == '0) ph = P_TAG1;
      end
    endcase
  endtask

  task automatic apply_reg(input logic [TLVP_ADDR_W-1:0] idx, input logic [TLVP_TOTAL_W-1:0] val);
    case (idx)
      TLVP_REG_TOTAL_SIZE:   m_total = val;
      TLVP_REG_INTEGER_CODE: m_int   = val[TLVP_CODE_W-1:0];
      TLVP_REG_STRING_CODE:  m_str   = val[TLVP_CODE_W-1:0];
      default:               m_set   = val[TLVP_CODE_W-1:0];
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: new input word and output ready at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    in_word_t w;
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(99) >= 30);
      // current word gone (or none held): offer the next one or idle
      if (!in_if.valid || in_taken) begin
        if (tx_words.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
          w = tx_words.pop_front();
          in_if.valid   <= 1'b1;
          in_if.in_byte <= w.b;
          in_if.first   <= w.first;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tlvp_res_t got;
    tlvp_res_t want;
    logic      moved;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      moved = 1'b0;
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        parse_byte(in_if.in_byte, in_if.first);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        apply_reg(cfg_if.addr, cfg_if.data);
        cfg_count <= cfg_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        moved          = 1'b1;
        got.kind       = out_if.kind;
        got.tag        = out_if.tag;
        got.data_type  = out_if.data_type;
        got.type_known = out_if.type_known;
        got.length     = out_if.length;
        got.value_byte = out_if.value_byte;
        got.last       = out_if.last;
        if (expected_words.size() == 0) begin
          // result the predictor never asked for
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected word: kind %0d tag %h type %h known %b len %h byte %h last %b",
                     got.kind, got.tag, got.data_type, got.type_known, got.length,
                     got.value_byte, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch exp: kind %0d tag %h type %h known %b len %h byte %h last %b",
                       want.kind, want.tag, want.data_type, want.type_known, want.length,
                       want.value_byte, want.last);
              $display("         got: kind %0d tag %h type %h known %b len %h byte %h last %b",
                       got.kind, got.tag, got.data_type, got.type_known, got.length,
                       got.value_byte, got.last);
            end
          end
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
      // watchdog: nothing has moved for far too long
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic write_reg(input logic [TLVP_ADDR_W-1:0] idx, input logic [TLVP_TOTAL_W-1:0] val);
    int unsigned seen;
    seen = cfg_count;
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(negedge clk); while (cfg_count == seen);
  endtask

  // sender holds off until the block has drained, then a few quiet cycles
  task automatic drain();
    while (tx_words.size() != 0 || in_if.valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // program all registers, send the frame, wait for every result
  task automatic run_buffer(input logic [TLVP_TOTAL_W-1:0] total,
                            input logic [TLVP_CODE_W-1:0] ic, input logic [TLVP_CODE_W-1:0] sc,
                            input logic [TLVP_CODE_W-1:0] stc, input logic restart);
    in_word_t w;
    @(negedge clk);
    write_reg(TLVP_REG_TOTAL_SIZE, total);
    write_reg(TLVP_REG_INTEGER_CODE, {28'd0, ic});
    write_reg(TLVP_REG_STRING_CODE, {28'd0, sc});
    write_reg(TLVP_REG_SET_CODE, {28'd0, stc});
    cfg_if.valid <= 1'b0;
    foreach (frame[i]) begin
      w.b = frame[i];
      // occasional restart in the middle of a buffer
      w.first = (i == 0) ? restart : ($urandom_range(99) == 0);
      tx_words.push_back(w);
    end
    bytes_queued += frame.size();
    frame.delete();
    drain();
  endtask

  // one element with random content, mostly well formed
  task automatic add_element();
    int unsigned sel;
    int unsigned vlen;
    int unsigned cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    // tag: short or two-byte, never the zero raw tag here
    if ($urandom_range(3) == 0) begin
      b0 = 8'h80 | 8'($urandom_range(127));
      b1 = 8'($urandom_range(255));
      if (b0 == 8'h80 && b1 == 8'h00) b1 = 8'h01;
      frame.push_back(b0);
      frame.push_back(b1);
    end else begin
      frame.push_back(8'($urandom_range(1, 127)));
    end
    vlen = 0;
    sel  = $urandom_range(9);
    if (sel <= 5) begin
      // short length, small value
      vlen = $urandom_range(0, 6);
      frame.push_back(8'(vlen));
    end else if (sel <= 7) begin
      // long form with a small big-endian length, count zero included
      cnt = $urandom_range(0, 3);
      if (cnt != 0) vlen = $urandom_range(0, 6);
      frame.push_back(8'h80 | 8'(cnt));
      for (int i = int'(cnt) - 1; i >= 0; i--) frame.push_back(8'(vlen >> (8 * i)));
    end else if (sel == 8) begin
      // long form with random, usually huge, length bytes
      cnt = $urandom_range(1, 12);
      frame.push_back(8'h80 | 8'(cnt));
      repeat (cnt) frame.push_back(8'($urandom_range(255)));
    end else begin
      // short length that usually runs past the end
      frame.push_back(8'($urandom_range(0, 127)));
      vlen = $urandom_range(0, 4);
    end
    repeat (vlen) frame.push_back(8'($urandom_range(255)));
  endtask

  // random buffer, appended to frame
  task automatic build_frame();
    int unsigned n;
    if ($urandom_range(99) < 15) begin
      // noise
      n = $urandom_range(1, 24);
      repeat (n) frame.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) add_element();
      case ($urandom_range(3))
        0: frame.push_back(8'h00);                            // zero raw tag
        1: begin                                              // tag zero, length zero
          frame.push_back(8'($urandom_range(0, 15)));
          frame.push_back(8'h00);
        end
        default: ;                                            // buffer simply runs out
      endcase
    end
  endtask

  function automatic logic [TLVP_CODE_W-1:0] pick_code();
    case ($urandom_range(5))
      0: return 4'h0;
      1: return 4'hF;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_no;
    int unsigned sz;
    int unsigned sel;
    logic [TLVP_TOTAL_W-1:0] total;

    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.first   = 1'b0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.addr   = TLVP_REG_TOTAL_SIZE;
    cfg_if.data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty buffer: everything dropped
    frame = '{8'h13, 8'h01};
    run_buffer('0, 4'd3, 4'd5, 4'd0, 1'b1);

    // walk through element forms: known header with value, two-byte tag at its
    // maximum, empty element, long form with count zero, overrun, tag zero with
    // a value, tag zero with length zero, one byte after the end marker
    frame = '{8'h13, 8'h02, 8'hFF, 8'h00,
              8'hFF, 8'hFF, 8'h81, 8'h01, 8'hAA,
              8'h25, 8'h00,
              8'h30, 8'h80,
              8'h40, 8'h7F,
              8'h01, 8'h01, 8'h55,
              8'h03, 8'h00,
              8'h7E};
    run_buffer(32'd20, 4'd3, 4'd5, 4'd0, 1'b1);

    // length count past the end, then a tag ending at the buffer end
    frame = '{8'h11, 8'h85, 8'h22};
    run_buffer(32'd3, 4'hF, 4'hF, 4'hF, 1'b1);

    // widest buffer, length keeps only its low 64 bits and overruns
    frame = '{8'hF0, 8'h01, 8'h89, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    run_buffer(32'hFFFF_FFFF, 4'h0, 4'h0, 4'h0, 1'b1);

    // random buffers, one register setting each
    phase_no = 0;
    while (bytes_queued < TARGET_BYTES) begin
      phase_no++;
      calm = (phase_no >= 30 && phase_no < 42);
      build_frame();
      sz  = frame.size();
      sel = $urandom_range(19);
      case (sel)
        0: total = 32'hFFFF_FFFF;
        1: total = $urandom;
        2, 3, 4: total = 32'(sz - ((sz > 3) ? $urandom_range(1, 3) : 0));
        5, 6: total = 32'(sz + $urandom_range(1, 4));
        default: total = 32'(sz);
      endcase
      run_buffer(total, pick_code(), pick_code(), pick_code(), $urandom_range(19) != 0);
    end
    calm = 1'b0;

    drain();
    repeat (10) @(posedge clk);
    // anything still expected never arrived
    errors += expected_words.size();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
